// File: src/lc3_instruction_executor_assert.svh
// Assertion macros used by the checker file of the instruction executor.
`ifndef LC3_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define LC3_INSTRUCTION_EXECUTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LC3_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lc3 check failed");

// The consequent must hold in the cycle after the antecedent.
`define LC3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lc3 check failed");

`endif

// File: src/lc3_pkg.sv
// ----------------------------------------------------------------------------
// lc3_pkg
// Types, codes and a helper function shared by the instruction executor.
// ----------------------------------------------------------------------------
package lc3_pkg;

  localparam int unsigned MemWordsDef = 65536;
  localparam logic [15:0] StartPcReset = 16'h3000;

  localparam logic [2:0] CcNeg  = 3'd4;
  localparam logic [2:0] CcZero = 3'd2;
  localparam logic [2:0] CcPos  = 3'd1;

  localparam logic [1:0] OpExec  = 2'd0;
  localparam logic [1:0] OpMemWr = 2'd1;
  localparam logic [1:0] OpMemRd = 2'd2;

  localparam logic [3:0] OpcBr  = 4'h0;
  localparam logic [3:0] OpcAdd = 4'h1;
  localparam logic [3:0] OpcLd  = 4'h2;
  localparam logic [3:0] OpcSt  = 4'h3;
  localparam logic [3:0] OpcJsr = 4'h4;
  localparam logic [3:0] OpcAnd = 4'h5;
  localparam logic [3:0] OpcLdr = 4'h6;
  localparam logic [3:0] OpcStr = 4'h7;
  localparam logic [3:0] OpcNot = 4'h9;
  localparam logic [3:0] OpcLdi = 4'hA;
  localparam logic [3:0] OpcSti = 4'hB;
  localparam logic [3:0] OpcJmp = 4'hC;
  localparam logic [3:0] OpcLea = 4'hE;

  localparam logic [2:0] LinkReg = 3'd7;

  typedef enum logic [4:0] {
    K_NOP, K_MWR, K_MRD, K_ADD, K_AND, K_NOT, K_LEA, K_LD, K_LDI,
    K_LDR, K_ST, K_STI, K_STR, K_BR, K_JMP, K_JSR, K_UNH
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] ir;
    logic [15:0] addr;
    logic [15:0] data;
  } item_t;

  function automatic logic [2:0] flags_of(logic [15:0] v);
    if (v[15]) begin
      return CcNeg;
    end else if (v == 16'h0000) begin
      return CcZero;
    end
    return CcPos;
  endfunction

endpackage

// File: src/lc3_instruction_executor.sv
// ----------------------------------------------------------------------------
// lc3_instruction_executor
// LC-3 instruction executor with its own registers, PC, flags and memory.
// ----------------------------------------------------------------------------
// After reset the block clears its word memory, one word per cycle, through
// all MEM_WORDS words (65536 by default); no request is accepted during that
// pass, and the configuration port is ready once the boot flag has cleared.
// Requests then pass a two-entry queue, so the input keeps accepting while a
// result waits, until it is full. Because the single memory port reads
// registered, LD, LDR and memory reads pass S_WAIT2, STI passes S_WAIT1 and
// LDI passes both; the back end takes every other request, one per cycle,
// while its result is not stalled.
module lc3_instruction_executor #(
  parameter int unsigned MEM_WORDS = lc3_pkg::MemWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] instruction_i,
  input  logic [15:0] address_i,
  input  logic [15:0] data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pc_now_o,
  output logic [2:0]  cond_flags_o,
  output logic        reg_written_o,
  output logic [2:0]  reg_index_o,
  output logic [15:0] reg_value_o,
  output logic        mem_written_o,
  output logic [15:0] mem_address_o,
  output logic [15:0] mem_data_o,
  output logic [15:0] read_data_o,
  output logic        unhandled_o
);
  import lc3_pkg::*;

  item_t push_item, head_item;
  logic  push, push_ready, pop, head_valid, run;

  lc3_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .instruction_i (instruction_i),
    .address_i     (address_i),
    .data_i        (data_i),
    .enable_i      (run),
    .push_ready_i  (push_ready),
    .push_o        (push),
    .item_o        (push_item)
  );

  lc3_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (head_valid),
    .pop_item_o   (head_item)
  );

  lc3_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .head_valid_i  (head_valid),
    .head_i        (head_item),
    .pop_o         (pop),
    .run_o         (run),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pc_now_o      (pc_now_o),
    .cond_flags_o  (cond_flags_o),
    .reg_written_o (reg_written_o),
    .reg_index_o   (reg_index_o),
    .reg_value_o   (reg_value_o),
    .mem_written_o (mem_written_o),
    .mem_address_o (mem_address_o),
    .mem_data_o    (mem_data_o),
    .read_data_o   (read_data_o),
    .unhandled_o   (unhandled_o)
  );

endmodule

// File: src/lc3_fifo.sv
// ----------------------------------------------------------------------------
// lc3_fifo
// Two-entry queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module lc3_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lc3_pkg::item_t push_item_i,
  output logic          push_ready_o,
  input  logic          pop_i,
  output logic          pop_valid_o,
  output lc3_pkg::item_t pop_item_o
);
  import lc3_pkg::*;

  item_t       slot_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// File: src/lc3_front.sv
// ----------------------------------------------------------------------------
// lc3_front
// Accepts requests and classifies each one into the kind of work it needs.
// ----------------------------------------------------------------------------
module lc3_front (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     operation_i,
  input  logic [15:0]    instruction_i,
  input  logic [15:0]    address_i,
  input  logic [15:0]    data_i,
  input  logic           enable_i,
  input  logic           push_ready_i,
  output logic           push_o,
  output lc3_pkg::item_t item_o
);
  import lc3_pkg::*;

  kind_e kind;

  always_comb begin
    kind = K_NOP;
    case (operation_i)
      OpMemWr: kind = K_MWR;
      OpMemRd: kind = K_MRD;
      OpExec: begin
        case (instruction_i[15:12])
          OpcBr:   kind = K_BR;
          OpcAdd:  kind = K_ADD;
          OpcLd:   kind = K_LD;
          OpcSt:   kind = K_ST;
          OpcJsr:  kind = K_JSR;
          OpcAnd:  kind = K_AND;
          OpcLdr:  kind = K_LDR;
          OpcStr:  kind = K_STR;
          OpcNot:  kind = K_NOT;
          OpcLdi:  kind = K_LDI;
          OpcSti:  kind = K_STI;
          OpcJmp:  kind = K_JMP;
          OpcLea:  kind = K_LEA;
          default: kind = K_UNH;
        endcase
      end
      default: kind = K_NOP;
    endcase
  end

  assign in_stall_o  = !(push_ready_i && enable_i);
  assign push_o      = in_valid_i && !in_stall_o;
  assign item_o.kind = kind;
  assign item_o.ir   = instruction_i;
  assign item_o.addr = address_i;
  assign item_o.data = data_i;

endmodule

// File: src/lc3_back.sv
// ----------------------------------------------------------------------------
// lc3_back
// Executes queued requests against the registers, PC, condition code and
// the single-port word memory, and holds the result register.
// ----------------------------------------------------------------------------
module lc3_back #(
  parameter int unsigned MEM_WORDS = lc3_pkg::MemWordsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i,
  input  logic           head_valid_i,
  input  lc3_pkg::item_t head_i,
  output logic           pop_o,
  output logic           run_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [15:0]    pc_now_o,
  output logic [2:0]     cond_flags_o,
  output logic           reg_written_o,
  output logic [2:0]     reg_index_o,
  output logic [15:0]    reg_value_o,
  output logic           mem_written_o,
  output logic [15:0]    mem_address_o,
  output logic [15:0]    mem_data_o,
  output logic [15:0]    read_data_o,
  output logic           unhandled_o
);
  import lc3_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  typedef enum logic [1:0] {S_CLEAR, S_RUN, S_WAIT1, S_WAIT2} state_e;

  state_e         state_q, state_d;
  logic           boot_q;
  logic [15:0]    start_pc_q;
  logic [15:0]    pc_q, pc_d;
  logic [2:0]     cc_q, cc_d;
  logic [15:0]    gpr_q [8];
  item_t          cur_q, cur_d;
  logic           rd_ok_q, rd_ok_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [15:0]    mem [MEM_WORDS];
  logic [15:0]    rdata_q;

  logic           m_we, m_re;
  logic [AW-1:0]  m_addr;
  logic [15:0]    m_wdata;

  logic           emit, setcc, out_free;
  logic           r_rw, r_mw, r_unh;
  logic [2:0]     r_ri;
  logic [15:0]    r_rv, r_ma, r_md, r_rd;

  logic [15:0]    ir, sr1, sr2, bval, off9, off6, imm5, off11, pc1, word, ea;
  logic [2:0]     dr;

  function automatic logic in_mem(logic [15:0] a);
    return {1'b0, a} < 17'(MEM_WORDS);
  endfunction

  assign cfg_ready_o = !boot_q;
  assign run_o       = (state_q != S_CLEAR);
  assign out_free    = !out_valid_o || !out_stall_i;

  assign ir    = (state_q == S_RUN) ? head_i.ir : cur_q.ir;
  assign dr    = ir[11:9];
  assign sr1   = gpr_q[ir[8:6]];
  assign sr2   = gpr_q[ir[2:0]];
  assign off9  = {{7{ir[8]}}, ir[8:0]};
  assign off6  = {{10{ir[5]}}, ir[5:0]};
  assign imm5  = {{11{ir[4]}}, ir[4:0]};
  assign off11 = {{5{ir[10]}}, ir[10:0]};
  assign bval  = ir[5] ? imm5 : sr2;
  assign pc1   = pc_q + 16'd1;
  assign word  = rd_ok_q ? rdata_q : 16'h0000;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    cc_d    = cc_q;
    cur_d   = cur_q;
    rd_ok_d = rd_ok_q;
    clr_d   = clr_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    setcc   = 1'b0;
    m_we    = 1'b0;
    m_re    = 1'b0;
    m_addr  = '0;
    m_wdata = 16'h0000;
    r_rw    = 1'b0;
    r_ri    = 3'd0;
    r_rv    = 16'h0000;
    r_mw    = 1'b0;
    r_ma    = 16'h0000;
    r_md    = 16'h0000;
    r_rd    = 16'h0000;
    r_unh   = 1'b0;
    ea      = 16'h0000;
    case (state_q)
      S_CLEAR: begin
        m_we  = 1'b1;
        m_addr = clr_q;
        clr_d = clr_q + 1'b1;
        if (boot_q) begin
          pc_d = start_pc_q;
        end
        if (clr_q == AW'(MEM_WORDS - 1)) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (head_valid_i && out_free) begin
          pop_o = 1'b1;
          cur_d = head_i;
          emit  = 1'b1;
          if (head_i.kind != K_NOP && head_i.kind != K_MWR && head_i.kind != K_MRD) begin
            pc_d = pc1;
          end
          case (head_i.kind)
            K_MWR: begin
              if (in_mem(head_i.addr)) begin
                m_we    = 1'b1;
                m_addr  = head_i.addr[AW-1:0];
                m_wdata = head_i.data;
              end
            end
            K_MRD: begin
              emit    = 1'b0;
              rd_ok_d = in_mem(head_i.addr);
              m_re    = in_mem(head_i.addr);
              m_addr  = head_i.addr[AW-1:0];
              state_d = S_WAIT2;
            end
            K_ADD, K_AND, K_NOT, K_LEA: begin
              r_rw  = 1'b1;
              r_ri  = dr;
              setcc = 1'b1;
              if (head_i.kind == K_ADD) begin
                r_rv = sr1 + bval;
              end else if (head_i.kind == K_AND) begin
                r_rv = sr1 & bval;
              end else if (head_i.kind == K_NOT) begin
                r_rv = ~sr1;
              end else begin
                r_rv = pc1 + off9;
              end
            end
            K_LD, K_LDI, K_LDR: begin
              emit    = 1'b0;
              ea      = (head_i.kind == K_LDR) ? (sr1 + off6) : (pc1 + off9);
              rd_ok_d = in_mem(ea);
              m_re    = in_mem(ea);
              m_addr  = ea[AW-1:0];
              state_d = (head_i.kind == K_LDI) ? S_WAIT1 : S_WAIT2;
            end
            K_ST, K_STR: begin
              ea = (head_i.kind == K_STR) ? (sr1 + off6) : (pc1 + off9);
              if (in_mem(ea)) begin
                m_we    = 1'b1;
                m_addr  = ea[AW-1:0];
                m_wdata = gpr_q[dr];
                r_mw    = 1'b1;
                r_ma    = ea;
                r_md    = gpr_q[dr];
              end
            end
            K_STI: begin
              emit    = 1'b0;
              ea      = pc1 + off9;
              rd_ok_d = in_mem(ea);
              m_re    = in_mem(ea);
              m_addr  = ea[AW-1:0];
              state_d = S_WAIT1;
            end
            K_BR: begin
              if ((dr & cc_q) != 3'd0) begin
                pc_d = pc1 + off9;
              end
            end
            K_JMP: begin
              pc_d = sr1;
            end
            K_JSR: begin
              pc_d = ir[11] ? (pc1 + off11) : sr1;
              r_rw = 1'b1;
              r_ri = LinkReg;
              r_rv = pc1;
            end
            K_UNH: begin
              r_unh = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_WAIT1: begin
        if (cur_q.kind == K_LDI) begin
          rd_ok_d = in_mem(word);
          m_re    = in_mem(word);
          m_addr  = word[AW-1:0];
          state_d = S_WAIT2;
        end else if (out_free) begin
          emit    = 1'b1;
          state_d = S_RUN;
          if (in_mem(word)) begin
            m_we    = 1'b1;
            m_addr  = word[AW-1:0];
            m_wdata = gpr_q[dr];
            r_mw    = 1'b1;
            r_ma    = word;
            r_md    = gpr_q[dr];
          end
        end
      end
      S_WAIT2: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_RUN;
          if (cur_q.kind == K_MRD) begin
            r_rd = word;
          end else begin
            r_rw  = 1'b1;
            r_ri  = dr;
            r_rv  = word;
            setcc = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
    if (setcc) begin
      cc_d = flags_of(r_rv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_we) begin
      mem[m_addr] <= m_wdata;
    end
    if (m_re) begin
      rdata_q <= mem[m_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      pc_now_o      <= pc_d;
      cond_flags_o  <= cc_d;
      reg_written_o <= r_rw;
      reg_index_o   <= r_ri;
      reg_value_o   <= r_rv;
      mem_written_o <= r_mw;
      mem_address_o <= r_ma;
      mem_data_o    <= r_md;
      read_data_o   <= r_rd;
      unhandled_o   <= r_unh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      boot_q      <= 1'b1;
      start_pc_q  <= StartPcReset;
      pc_q        <= StartPcReset;
      cc_q        <= CcZero;
      rd_ok_q     <= 1'b0;
      clr_q       <= '0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        gpr_q[i] <= 16'h0000;
      end
    end else begin
      state_q <= state_d;
      boot_q  <= 1'b0;
      pc_q    <= pc_d;
      cc_q    <= cc_d;
      rd_ok_q <= rd_ok_d;
      clr_q   <= clr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        start_pc_q <= cfg_data_i;
      end
      if (r_rw) begin
        gpr_q[r_ri] <= r_rv;
      end
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

// File: src/lc3_checker.sv
// ----------------------------------------------------------------------------
// lc3_checker
// Port-level checks of the instruction executor, bound to the top level.
// ----------------------------------------------------------------------------
`include "lc3_instruction_executor_assert.svh"

module lc3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [15:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  operation_i,
  input logic [15:0] instruction_i,
  input logic [15:0] address_i,
  input logic [15:0] data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] pc_now_o,
  input logic [2:0]  cond_flags_o,
  input logic        reg_written_o,
  input logic [2:0]  reg_index_o,
  input logic [15:0] reg_value_o,
  input logic        mem_written_o,
  input logic [15:0] mem_address_o,
  input logic [15:0] mem_data_o,
  input logic [15:0] read_data_o,
  input logic        unhandled_o
);

  `LC3_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(pc_now_o))
  `LC3_ASSERT_NOW(a_unh_quiet, out_valid_o && unhandled_o, !reg_written_o && !mem_written_o)
  `LC3_ASSERT_NOW(a_no_reg, out_valid_o && !reg_written_o, reg_index_o == 3'd0 && reg_value_o == 16'h0000)
  `LC3_ASSERT_NOW(a_store_only, out_valid_o && mem_written_o, !reg_written_o && read_data_o == 16'h0000)

endmodule

bind lc3_instruction_executor lc3_checker u_checker (.*);

// File: tb/lc3_instruction_executor_tb.sv
// ----------------------------------------------------------------------------
// lc3_instruction_executor_tb
// Self-checking testbench for the LC-3 instruction executor. A driver and a
// monitor, both clocked, move requests and results through the stall
// handshakes with random idle bursts on both sides. A behavioral model of the
// registers, PC, condition code and memory predicts every result, and the
// monitor compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lc3_instruction_executor_tb;
  import lc3_pkg::*;

  localparam logic [1:0] OpNone   = 2'd3;
  localparam logic [3:0] OpcRti   = 4'h8;
  localparam logic [3:0] OpcRsv   = 4'hD;
  localparam logic [3:0] OpcTrap  = 4'hF;
  localparam int unsigned CycleLimit = 2_000_000;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] ir;
    logic [15:0] addr;
    logic [15:0] data;
  } request_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [2:0]  cc;
    logic        rw;
    logic [2:0]  ri;
    logic [15:0] rv;
    logic        mw;
    logic [15:0] ma;
    logic [15:0] md;
    logic [15:0] rd;
    logic        unh;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [15:0] instruction_i = '0;
  logic [15:0] address_i = '0;
  logic [15:0] data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] pc_now_o;
  logic [2:0]  cond_flags_o;
  logic        reg_written_o;
  logic [2:0]  reg_index_o;
  logic [15:0] reg_value_o;
  logic        mem_written_o;
  logic [15:0] mem_address_o;
  logic [15:0] mem_data_o;
  logic [15:0] read_data_o;
  logic        unhandled_o;

  lc3_instruction_executor u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .operation_i, .instruction_i, .address_i, .data_i,
    .out_valid_o, .out_stall_i, .pc_now_o, .cond_flags_o, .reg_written_o,
    .reg_index_o, .reg_value_o, .mem_written_o, .mem_address_o, .mem_data_o,
    .read_data_o, .unhandled_o
  );

  always #5 clk_i = ~clk_i;

  request_t    pending_requests[$];
  outcome_t    expected_outcomes[$];
  request_t    driven_request;
  logic [15:0] gpr[8];
  logic [15:0] pc_model = StartPcReset;
  logic [2:0]  cc_model = CcZero;
  logic [15:0] mem_model[0:65535];
  int          in_gap = 0;
  int          out_gap = 0;
  bit          calm = 1'b0;
  int          mismatches = 0;
  int unsigned cycles = 0;

  function automatic logic [15:0] sext(logic [15:0] v, int bits);
    logic [15:0] m;
    m = (16'h1 << bits) - 16'h1;
    v = v & m;
    if (v[bits-1]) begin
      v = v | ~m;
    end
    return v;
  endfunction

  function automatic logic [2:0] cc_of(logic [15:0] v);
    if (v[15]) begin
      return CcNeg;
    end
    return (v == 16'h0) ? CcZero : CcPos;
  endfunction

  function automatic outcome_t execute_request(request_t q);
    outcome_t    o;
    logic [3:0]  opc;
    logic [2:0]  dr;
    logic [15:0] sr1, b, nxt, ea, off9, off6;
    logic        setcc;
    o = '0;
    setcc = 1'b0;
    if (q.op == OpMemWr) begin
      mem_model[q.addr] = q.data;
    end else if (q.op == OpMemRd) begin
      o.rd = mem_model[q.addr];
    end else if (q.op == OpExec) begin
      opc = q.ir[15:12];
      dr = q.ir[11:9];
      sr1 = gpr[q.ir[8:6]];
      off9 = sext(q.ir, 9);
      off6 = sext(q.ir, 6);
      b = q.ir[5] ? sext(q.ir, 5) : gpr[q.ir[2:0]];
      nxt = pc_model + 16'h1;
      pc_model = nxt;
      case (opc)
        OpcBr: begin
          if ((dr & cc_model) != 3'b0) begin
            pc_model = nxt + off9;
          end
        end
        OpcAdd: begin o.rw = 1; o.ri = dr; o.rv = sr1 + b; setcc = 1; end
        OpcAnd: begin o.rw = 1; o.ri = dr; o.rv = sr1 & b; setcc = 1; end
        OpcNot: begin o.rw = 1; o.ri = dr; o.rv = ~sr1; setcc = 1; end
        OpcLd: begin o.rw = 1; o.ri = dr; o.rv = mem_model[nxt + off9]; setcc = 1; end
        OpcLdi: begin
          o.rw = 1; o.ri = dr; o.rv = mem_model[mem_model[nxt + off9]]; setcc = 1;
        end
        OpcLdr: begin o.rw = 1; o.ri = dr; o.rv = mem_model[sr1 + off6]; setcc = 1; end
        OpcLea: begin o.rw = 1; o.ri = dr; o.rv = nxt + off9; setcc = 1; end
        OpcSt, OpcSti, OpcStr: begin
          if (opc == OpcSt) begin
            ea = nxt + off9;
          end else if (opc == OpcSti) begin
            ea = mem_model[nxt + off9];
          end else begin
            ea = sr1 + off6;
          end
          mem_model[ea] = gpr[dr];
          o.mw = 1; o.ma = ea; o.md = gpr[dr];
        end
        OpcJmp: pc_model = sr1;
        OpcJsr: begin
          pc_model = q.ir[11] ? nxt + sext(q.ir, 11) : sr1;
          o.rw = 1; o.ri = LinkReg; o.rv = nxt;
        end
        default: o.unh = 1;
      endcase
      if (o.rw) begin
        gpr[o.ri] = o.rv;
      end
      if (setcc) begin
        cc_model = cc_of(o.rv);
      end
    end
    o.pc = pc_model;
    o.cc = cc_model;
    return o;
  endfunction

  function automatic request_t exec_req(logic [3:0] opc, logic [2:0] a, logic [8:0] low);
    return '{OpExec, {opc, a, low}, 16'h0, 16'h0};
  endfunction

  function automatic logic [15:0] near_addr();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : {8'h30, 8'($urandom)};
  endfunction

  function automatic request_t random_request();
    request_t q;
    int       r;
    q.op = OpExec;
    q.ir = 16'($urandom);
    q.addr = near_addr();
    q.data = $urandom_range(0, 1) ? near_addr() : 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 14) begin
      q.op = OpMemWr;
    end else if (r < 22) begin
      q.op = OpMemRd;
    end else if (r < 24) begin
      q.op = OpNone;
    end else if (r < 34) begin
      q.ir[15:12] = OpcBr;
      q.ir[8] = q.ir[8] & q.ir[7];
    end
    return q;
  endfunction

  task automatic write_start_pc(logic [15:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || in_valid_i || expected_outcomes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_outcomes.push_back(execute_request(driven_request));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 9);
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          driven_request = pending_requests.pop_front();
          operation_i <= driven_request.op;
          instruction_i <= driven_request.ir;
          address_i <= driven_request.addr;
          data_i <= driven_request.data;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t act, exp_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        act = '{pc_now_o, cond_flags_o, reg_written_o, reg_index_o, reg_value_o,
                mem_written_o, mem_address_o, mem_data_o, read_data_o, unhandled_o};
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result %p", act);
          end
        end else begin
          exp_o = expected_outcomes.pop_front();
          if (act.pc !== exp_o.pc || act.cc !== exp_o.cc || act.rw !== exp_o.rw ||
              act.ri !== exp_o.ri || act.rv !== exp_o.rv || act.mw !== exp_o.mw ||
              act.ma !== exp_o.ma || act.md !== exp_o.md || act.rd !== exp_o.rd ||
              act.unh !== exp_o.unh) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch\n  expected %p\n  actual   %p", exp_o, act);
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 9);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("lc3_instruction_executor test failed");
      $finish;
    end
  end

  initial begin
    foreach (gpr[i]) gpr[i] = '0;
    foreach (mem_model[i]) mem_model[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_start_pc(16'h0000);

    pending_requests.push_back('{OpMemWr, 16'h0, 16'h3005, 16'h8000});
    pending_requests.push_back('{OpMemWr, 16'h0, 16'hFFFF, 16'h3005});
    pending_requests.push_back('{OpMemWr, 16'h0, 16'h0000, 16'h7FFF});
    pending_requests.push_back(exec_req(OpcAdd, 3'd1, {3'd0, 6'h30}));
    pending_requests.push_back(exec_req(OpcAdd, 3'd2, {3'd1, 6'h2F}));
    pending_requests.push_back(exec_req(OpcAdd, 3'd3, {3'd1, 6'h02}));
    pending_requests.push_back(exec_req(OpcAnd, 3'd4, {3'd3, 6'h3F}));
    pending_requests.push_back(exec_req(OpcAnd, 3'd5, {3'd1, 6'h02}));
    pending_requests.push_back(exec_req(OpcNot, 3'd6, {3'd0, 6'h3F}));
    pending_requests.push_back(exec_req(OpcLea, 3'd0, 9'h100));
    pending_requests.push_back(exec_req(OpcLea, 3'd0, 9'h0FF));
    pending_requests.push_back(exec_req(OpcLd, 3'd1, 9'h1F0));
    pending_requests.push_back(exec_req(OpcLdi, 3'd2, 9'h1FF));
    pending_requests.push_back(exec_req(OpcLdr, 3'd3, {3'd6, 6'h01}));
    pending_requests.push_back(exec_req(OpcLdr, 3'd3, {3'd6, 6'h20}));
    pending_requests.push_back(exec_req(OpcSt, 3'd6, 9'h000));
    pending_requests.push_back(exec_req(OpcSti, 3'd1, 9'h1FF));
    pending_requests.push_back(exec_req(OpcStr, 3'd5, {3'd0, 6'h1F}));
    pending_requests.push_back(exec_req(OpcBr, 3'd7, 9'h1FF));
    pending_requests.push_back(exec_req(OpcBr, 3'd4, 9'h0FF));
    pending_requests.push_back(exec_req(OpcBr, 3'd0, 9'h010));
    pending_requests.push_back(exec_req(OpcJmp, 3'd0, {3'd6, 6'h00}));
    pending_requests.push_back(exec_req(OpcJsr, 3'd4, 9'h000));
    pending_requests.push_back(exec_req(OpcJsr, 3'd0, {3'd7, 6'h00}));
    pending_requests.push_back(exec_req(OpcJmp, 3'd0, {3'd7, 6'h00}));
    pending_requests.push_back('{OpExec, {OpcTrap, 12'h025}, 16'h0, 16'h0});
    pending_requests.push_back('{OpExec, {OpcRti, 12'h000}, 16'h0, 16'h0});
    pending_requests.push_back('{OpExec, {OpcRsv, 12'hFFF}, 16'h0, 16'h0});
    pending_requests.push_back('{OpMemRd, 16'h0, 16'hFFFF, 16'h0});
    pending_requests.push_back('{OpNone, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    drain();

    write_start_pc(16'hFFFF);
    repeat (400) pending_requests.push_back(random_request());
    drain();

    write_start_pc(16'($urandom));
    repeat (400) pending_requests.push_back(random_request());
    drain();

    write_start_pc(StartPcReset);
    calm = 1'b1;
    repeat (150) pending_requests.push_back(random_request());
    drain();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("lc3_instruction_executor test passed");
    end else begin
      $display("lc3_instruction_executor test failed");
    end
    $finish;
  end

endmodule
